/* src/dlfcd_pkg.sv */
// Shared types and constants for the debug link frame command decoder.
// Used by dlfcd_cmd, dlfcd_seq and debug_link_frame_command_decoder; no dependencies.
package dlfcd_pkg;

    localparam int BUFFER_BYTES = 32;   // frame buffer depth, 8..64
    localparam int BC_W         = 6;    // byte counter width
    localparam int HDR_BYTES    = 6;    // leading bytes that commands ever look at
    localparam int HDR_IDX_W    = $clog2(HDR_BYTES);
    localparam int STEP_W       = 3;    // up to seven results per byte
    localparam int TDATA_W      = 72;

    localparam logic [7:0] DELIM    = 8'h7E;
    localparam logic [7:0] ESC      = 8'h7D;
    localparam logic [7:0] ESC_XOR  = 8'h20;
    localparam logic [7:0] CH_HELLO = 8'h68;  // 'h'
    localparam logic [7:0] CH_EXEC  = 8'h78;  // 'x'
    localparam logic [7:0] CH_RESET = 8'h72;  // 'r'
    localparam logic [7:0] CH_WRITE = 8'h77;  // 'w'
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_K     = 8'h4B;

    localparam logic [1:0] SPACE_BYTECODE = 2'd0;
    localparam logic [1:0] SPACE_LAST     = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_REPLY        = 2'd0;
    localparam logic [1:0] KIND_MEM_WRITE    = 2'd1;
    localparam logic [1:0] KIND_THREAD_RESET = 2'd2;
    localparam logic [1:0] KIND_START_EXEC   = 2'd3;

    // Result sequence started by one input byte
    typedef enum logic [2:0] {
        SEQ_HELLO  = 3'd0,
        SEQ_RESET  = 3'd1,
        SEQ_EXEC   = 3'd2,
        SEQ_WREPLY = 3'd3,
        SEQ_MEMW   = 3'd4
    } seq_t;

    typedef struct packed {
        seq_t        seq;
        logic [1:0]  space;
        logic [15:0] addr;
        logic [7:0]  data;
        logic [16:0] code_len;
        logic [7:0]  fn_num;
        logic [7:0]  arg_count;
    } desc_t;

    function automatic logic [7:0] hello_byte(input logic [STEP_W-1:0] idx);
        logic [7:0] r;
        case (idx)
            3'd1:    r = CH_HELLO;
            3'd2:    r = CH_S;
            3'd3:    r = CH_T;
            3'd4:    r = CH_A;
            3'd5:    r = CH_K;
            default: r = DELIM;
        endcase
        return r;
    endfunction

endpackage

/* src/dlfcd_cmd.sv */
// Unstuffing state machine, header buffer and command interpreter.
// Depends on dlfcd_pkg; emits one result descriptor per accepted byte at most.
module dlfcd_cmd (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            accept,
    input  logic [7:0]      rx_byte,
    output logic            emit,
    output dlfcd_pkg::desc_t desc
);
    import dlfcd_pkg::*;

    typedef enum logic [2:0] {
        FS_WAIT = 3'b001,
        FS_IN   = 3'b010,
        FS_ESC  = 3'b100
    } frame_state_t;

    typedef enum logic [2:0] {
        CS_IDLE  = 3'b001,
        CS_RECV  = 3'b010,
        CS_WRITE = 3'b100
    } cmd_state_t;

    typedef enum logic [1:0] {
        EV_DATA  = 2'd0,
        EV_END   = 2'd1,
        EV_ABORT = 2'd2
    } ev_t;

    frame_state_t          frame_state_reg, frame_state_next, frame_state_eff;
    cmd_state_t            cmd_state_reg, cmd_state_next, cmd_state_eff;
    logic [BC_W-1:0]       byte_count_reg, byte_count_next, byte_count_eff;
    logic [1:0]            write_space_reg, write_space_next;
    logic [16:0]           write_pointer_reg, write_pointer_next;
    logic                  write_enabled_reg, write_enabled_next;
    logic [16:0]           bytecode_size_reg, bytecode_size_next;
    logic [7:0]            hdr_reg [HDR_BYTES];

    logic                  overflow;
    logic                  proceed;
    ev_t                   ev;
    logic [7:0]            data_b;
    logic                  hdr_we;
    logic [HDR_IDX_W-1:0]  hdr_idx;
    logic [16:0]           hdr_sum;

    // Overflow check happens before anything else sees the byte
    assign overflow = ({1'b0, byte_count_reg} + 7'd1) >= 7'(BUFFER_BYTES);
    assign frame_state_eff = overflow ? FS_WAIT : frame_state_reg;
    assign cmd_state_eff   = overflow ? CS_IDLE : cmd_state_reg;
    assign byte_count_eff  = overflow ? '0 : byte_count_reg;

    // off + cnt of a write header; the last header byte is the one arriving now
    assign hdr_sum = {1'b0, hdr_reg[3], hdr_reg[2]} + {1'b0, data_b, hdr_reg[4]};

    always_comb begin
        frame_state_next   = frame_state_eff;
        cmd_state_next     = cmd_state_eff;
        byte_count_next    = byte_count_eff;
        write_space_next   = write_space_reg;
        write_pointer_next = write_pointer_reg;
        write_enabled_next = write_enabled_reg;
        bytecode_size_next = bytecode_size_reg;
        proceed            = 1'b0;
        ev                 = EV_DATA;
        data_b             = rx_byte;
        hdr_we             = 1'b0;
        hdr_idx            = '0;
        emit               = 1'b0;
        desc               = '0;
        desc.seq           = SEQ_HELLO;
        desc.code_len      = bytecode_size_reg;

        unique case (frame_state_eff)
            FS_IN: begin
                if (rx_byte == ESC) begin
                    frame_state_next = FS_ESC;
                end else begin
                    proceed = 1'b1;
                    ev      = (rx_byte == DELIM) ? EV_END : EV_DATA;
                end
            end
            FS_ESC: begin
                frame_state_next = FS_IN;
                proceed          = 1'b1;
                if (rx_byte == DELIM) begin
                    ev = EV_ABORT;
                end else begin
                    data_b = rx_byte ^ ESC_XOR;
                end
            end
            FS_WAIT: begin
                if (rx_byte == DELIM) begin
                    frame_state_next = FS_IN;
                end
            end
            default: frame_state_next = FS_WAIT;
        endcase

        if (proceed) begin
            unique case (cmd_state_eff)
                CS_IDLE: begin
                    if (ev == EV_DATA) begin
                        hdr_we          = 1'b1;
                        hdr_idx         = '0;
                        byte_count_next = BC_W'(1);
                        cmd_state_next  = CS_RECV;
                    end
                end
                CS_RECV: begin
                    if (ev == EV_ABORT) begin
                        cmd_state_next = CS_IDLE;
                    end else if (ev == EV_END) begin
                        cmd_state_next = CS_IDLE;
                        if (hdr_reg[0] == CH_HELLO && byte_count_eff == BC_W'(1)) begin
                            emit     = 1'b1;
                            desc.seq = SEQ_HELLO;
                        end else if (hdr_reg[0] == CH_RESET
                                     && byte_count_eff == BC_W'(1)) begin
                            emit     = 1'b1;
                            desc.seq = SEQ_RESET;
                        end else if (hdr_reg[0] == CH_EXEC
                                     && byte_count_eff == BC_W'(3)) begin
                            emit            = 1'b1;
                            desc.seq        = SEQ_EXEC;
                            desc.fn_num     = hdr_reg[1];
                            desc.arg_count  = hdr_reg[2];
                        end
                    end else begin
                        if ({1'b0, byte_count_eff} < 7'(BUFFER_BYTES)) begin
                            byte_count_next = byte_count_eff + BC_W'(1);
                            if ({1'b0, byte_count_eff} < 7'(HDR_BYTES)) begin
                                hdr_we  = 1'b1;
                                hdr_idx = byte_count_eff[HDR_IDX_W-1:0];
                            end
                        end
                        if (hdr_reg[0] == CH_WRITE && byte_count_next == BC_W'(HDR_BYTES)) begin
                            write_space_next   = hdr_reg[1][1:0];
                            write_enabled_next = (hdr_reg[1] <= {6'd0, SPACE_LAST});
                            write_pointer_next = {1'b0, hdr_reg[3], hdr_reg[2]};
                            if (hdr_reg[1] == {6'd0, SPACE_BYTECODE}
                                && bytecode_size_reg < hdr_sum) begin
                                bytecode_size_next = hdr_sum;
                            end
                            cmd_state_next = CS_WRITE;
                        end
                    end
                end
                CS_WRITE: begin
                    if (ev != EV_DATA) begin
                        emit           = 1'b1;
                        desc.seq       = SEQ_WREPLY;
                        cmd_state_next = CS_IDLE;
                    end else begin
                        // drop writes to a bad space or past the top of the space
                        if (write_enabled_reg && !write_pointer_reg[16]) begin
                            emit       = 1'b1;
                            desc.seq   = SEQ_MEMW;
                            desc.space = write_space_reg;
                            desc.addr  = write_pointer_reg[15:0];
                            desc.data  = data_b;
                        end
                        if (!write_pointer_reg[16]) begin
                            write_pointer_next = write_pointer_reg + 17'd1;
                        end
                    end
                end
                default: cmd_state_next = CS_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_state_reg   <= FS_WAIT;
            cmd_state_reg     <= CS_IDLE;
            byte_count_reg    <= '0;
            write_space_reg   <= '0;
            write_pointer_reg <= '0;
            write_enabled_reg <= 1'b0;
            bytecode_size_reg <= '0;
        end else if (accept) begin
            frame_state_reg   <= frame_state_next;
            cmd_state_reg     <= cmd_state_next;
            byte_count_reg    <= byte_count_next;
            write_space_reg   <= write_space_next;
            write_pointer_reg <= write_pointer_next;
            write_enabled_reg <= write_enabled_next;
            bytecode_size_reg <= bytecode_size_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && hdr_we) begin
            hdr_reg[hdr_idx] <= data_b;
        end
    end

endmodule

/* src/dlfcd_seq.sv */
// Result sequencer: holds one descriptor and plays out its results, one per
// cycle while m_tready is high. Depends on dlfcd_pkg.
module dlfcd_seq (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            load,
    input  dlfcd_pkg::desc_t                desc_in,
    input  logic                            m_tready,
    output logic                            m_tvalid,
    output logic                            m_tlast,
    output logic [1:0]                      m_tuser,
    output logic [dlfcd_pkg::TDATA_W-1:0]   m_tdata,
    output logic                            free
);
    import dlfcd_pkg::*;

    desc_t               desc_reg;
    logic                valid_reg;
    logic [STEP_W-1:0]   step_reg;

    logic [7:0]  reply;
    logic [1:0]  kind;
    logic [1:0]  space;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [7:0]  fi;
    logic [7:0]  ac;
    logic        last;

    always_comb begin
        kind  = KIND_REPLY;
        reply = '0;
        space = '0;
        addr  = '0;
        data  = '0;
        fi    = '0;
        ac    = '0;
        last  = 1'b0;
        case (desc_reg.seq)
            SEQ_HELLO: begin
                reply = hello_byte(step_reg);
                last  = (step_reg == STEP_W'(6));
            end
            SEQ_RESET, SEQ_EXEC: begin
                last = (step_reg == STEP_W'(2));
                if (step_reg == '0) begin
                    if (desc_reg.seq == SEQ_EXEC) begin
                        kind = KIND_START_EXEC;
                        fi   = desc_reg.fn_num;
                        ac   = desc_reg.arg_count;
                    end else begin
                        kind = KIND_THREAD_RESET;
                    end
                end else if (step_reg == STEP_W'(1)) begin
                    reply = (desc_reg.seq == SEQ_EXEC) ? CH_EXEC : CH_RESET;
                end else begin
                    reply = DELIM;
                end
            end
            SEQ_WREPLY: begin
                last  = (step_reg == STEP_W'(1));
                reply = (step_reg == '0) ? CH_WRITE : DELIM;
            end
            SEQ_MEMW: begin
                kind  = KIND_MEM_WRITE;
                space = desc_reg.space;
                addr  = desc_reg.addr;
                data  = desc_reg.data;
                last  = 1'b1;
            end
            default: last = 1'b1;
        endcase
    end

    assign m_tvalid = valid_reg;
    assign m_tlast  = last;
    assign m_tuser  = kind;
    assign m_tdata  = {5'd0, ac, fi, desc_reg.code_len, data, addr, space, reply};
    assign free     = !valid_reg || (last && m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            step_reg  <= '0;
        end else if (load) begin
            valid_reg <= 1'b1;
            step_reg  <= '0;
        end else if (valid_reg && m_tready) begin
            if (last) begin
                valid_reg <= 1'b0;
            end
            step_reg <= step_reg + STEP_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            desc_reg <= desc_in;
        end
    end

endmodule

/* src/debug_link_frame_command_decoder.sv */
// Top level of the debug link frame command decoder.
// Depends on dlfcd_pkg, dlfcd_cmd and dlfcd_seq.
//
// Usage:
//   The slave channel takes one raw link byte per transfer in s_tdata. Bytes
//   are unstuffed (0x7E delimits, 0x7D escapes with XOR 0x20, escaped 0x7E
//   aborts), buffered and decoded as hello, reset, start-execution or memory
//   write commands.
//   The master channel carries the results: m_tuser holds the kind (reply
//   byte, memory write, thread reset, begin execution), m_tdata the payload,
//   and m_tlast marks the final result caused by one input byte.
//   A result appears on the master side in the cycle after its byte is
//   accepted. Throughput while m_tready is high: one byte per cycle while
//   each byte causes at most one result; a byte with k results (seven for
//   HELLO) holds the master side until all are taken, as the sequencer plays
//   out one transfer per cycle and takes a new byte only as its last result
//   leaves. Bytes with no result pass at one per cycle while it is free.
//   Reset: aresetn clears both state machines, counters and the bytecode
//   length, and empties the result register.
//   Stall: when m_tready is low, the pending result holds and s_tready drops
//   until its last result has been taken.
module debug_link_frame_command_decoder (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] rx_byte
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [dlfcd_pkg::TDATA_W-1:0]  m_tdata,   // [7:0] reply_byte, [9:8] mem_space,
                                                      // [25:10] mem_address, [33:26] mem_data,
                                                      // [50:34] code_length, [58:51] function
                                                      // number, [66:59] arg_count, [71:67] zero
    output logic [1:0]                     m_tuser,   // [1:0] kind
    output logic                           m_tlast
);
    import dlfcd_pkg::*;

    logic  s_accept;
    logic  emit;
    logic  seq_free;
    desc_t desc;

    // Take a new byte whenever the result register is empty or draining its last result
    assign s_tready = seq_free;
    assign s_accept = s_tvalid && s_tready;

    dlfcd_cmd u_cmd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (s_accept),
        .rx_byte (s_tdata),
        .emit    (emit),
        .desc    (desc)
    );

    // Load the sequencer only for bytes that produce results
    dlfcd_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (s_accept && emit),
        .desc_in  (desc),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata),
        .free     (seq_free)
    );

    // A byte is taken while results are pending only as the last one leaves
    a_accept_on_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready && m_tvalid |-> m_tlast && m_tready)
        else $error("input taken while results still pending");

    // A memory write is always the only result of its byte
    a_memw_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_MEM_WRITE |-> m_tlast)
        else $error("memory write not marked last");

    // Thread reset and begin execution are always followed by their reply
    a_event_has_reply: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_THREAD_RESET || m_tuser == KIND_START_EXEC)
        |-> !m_tlast)
        else $error("event result without following reply");

endmodule
